>>> rtl/core/lph_pkg.sv
// Shared types and constants for the linear probing hash table unit.
// No dependencies; used by every module under rtl/core.
package lph_pkg;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic [2:0] STAT_INSERTED = 3'd0;
  localparam logic [2:0] STAT_UPDATED  = 3'd1;
  localparam logic [2:0] STAT_FULL     = 3'd2;
  localparam logic [2:0] STAT_HIT      = 3'd3;
  localparam logic [2:0] STAT_MISS     = 3'd4;

  // splitmix64 finalizer constants
  localparam logic [63:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_C2 = 64'h94d049bb133111eb;
  localparam int MIX_SH1 = 30;
  localparam int MIX_SH2 = 27;
  localparam int MIX_SH3 = 31;

  // queue between hash front and probe back
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;
  localparam int CRED_W = 3;

  typedef struct packed {
    logic        op;
    logic [63:0] key;
    logic [63:0] val;
  } item_t;

  typedef struct packed {
    logic clearing;
    logic pop;
  } back_stat_t;

  function automatic logic [63:0] mul32(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] p;
    p = {32'd0, a} * {32'd0, b};
    return p;
  endfunction

endpackage

>>> rtl/core/lph_hash_front.sv
// Front end: accepts transactions, runs the splitmix64 mix in five stages and
// pushes item plus home slot into the queue. Uses lph_pkg.
module lph_hash_front import lph_pkg::*; #(
  parameter int AW = 10
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  logic          in_opcode,
  input  logic [63:0]   in_lookup_key,
  input  logic [63:0]   in_write_value,
  input  back_stat_t    bstat,
  output logic          push,
  output item_t         push_item,
  output logic [AW-1:0] push_pos
);

  logic              accept;
  logic [CRED_W-1:0] cred_r, cred_nxt;
  logic [4:0]        v_r;
  item_t             it_r [5];
  logic [63:0]       x1_r, x3_r;
  logic [63:0]       pl2_r, pl4_r;
  logic [31:0]       pa2_r, pb2_r, pa4_r, pb4_r;
  logic [AW-1:0]     pos5_r;
  logic [63:0]       m1, m2, x2, x4;

  // credits count items in the pipe plus the queue, so a push never overflows
  assign busy   = bstat.clearing || (cred_r == CRED_W'(QDEPTH));
  assign accept = start && !busy;

  always_comb begin
    cred_nxt = cred_r;
    if (accept && !bstat.pop) begin
      cred_nxt = cred_r + 1'b1;
    end else if (!accept && bstat.pop) begin
      cred_nxt = cred_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cred_r <= '0;
      v_r    <= '0;
    end else begin
      cred_r <= cred_nxt;
      v_r    <= {v_r[3:0], accept};
    end
  end

  assign m1 = pl2_r + {pa2_r + pb2_r, 32'd0};
  assign x2 = m1 ^ (m1 >> MIX_SH2);
  assign m2 = pl4_r + {pa4_r + pb4_r, 32'd0};
  assign x4 = m2 ^ (m2 >> MIX_SH3);

  always_ff @(posedge clk) begin
    it_r[0] <= '{op: in_opcode, key: in_lookup_key, val: in_write_value};
    x1_r    <= in_lookup_key ^ (in_lookup_key >> MIX_SH1);
    // 64x64 low product as three 32x32 partial products
    it_r[1] <= it_r[0];
    pl2_r   <= mul32(x1_r[31:0], MIX_C1[31:0]);
    pa2_r   <= 32'(mul32(x1_r[31:0], MIX_C1[63:32]));
    pb2_r   <= 32'(mul32(x1_r[63:32], MIX_C1[31:0]));
    it_r[2] <= it_r[1];
    x3_r    <= x2;
    it_r[3] <= it_r[2];
    pl4_r   <= mul32(x3_r[31:0], MIX_C2[31:0]);
    pa4_r   <= 32'(mul32(x3_r[31:0], MIX_C2[63:32]));
    pb4_r   <= 32'(mul32(x3_r[63:32], MIX_C2[31:0]));
    it_r[4] <= it_r[3];
    pos5_r  <= x4[AW-1:0];
  end

  assign push      = v_r[4];
  assign push_item = it_r[4];
  assign push_pos  = pos5_r;

endmodule

>>> rtl/core/lph_queue.sv
// Small FIFO between the hash front and the probe back.
// Uses lph_pkg for depth and the item type.
module lph_queue import lph_pkg::*; #(
  parameter int AW = 10
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  item_t         push_item,
  input  logic [AW-1:0] push_pos,
  input  logic          pop,
  output logic          empty,
  output item_t         head_item,
  output logic [AW-1:0] head_pos
);

  item_t         item_q [QDEPTH];
  logic [AW-1:0] pos_q  [QDEPTH];
  logic [QAW-1:0] wp_r, rp_r;
  logic [QAW:0]   cnt_r;

  assign empty     = (cnt_r == '0);
  assign head_item = item_q[rp_r];
  assign head_pos  = pos_q[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (!push && pop) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      item_q[wp_r] <= push_item;
      pos_q[wp_r]  <= push_pos;
    end
  end

endmodule

>>> rtl/core/lph_probe_back.sv
// Probe engine: holds the slot memories, walks the probe sequence and
// produces one result per transaction. Uses lph_pkg.
module lph_probe_back import lph_pkg::*; #(
  parameter int SLOTS = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  input  item_t         q_item,
  input  logic [AW-1:0] q_pos,
  output back_stat_t    bstat,
  output logic          out_valid,
  output logic [2:0]    out_status,
  output logic [63:0]   out_read_value
);

  localparam logic [1:0] S_CLR  = 2'd0;
  localparam logic [1:0] S_IDLE = 2'd1;
  localparam logic [1:0] S_CMP  = 2'd2;

  logic [63:0] key_mem [SLOTS];
  logic [63:0] val_mem [SLOTS];
  logic        vld_mem [SLOTS];

  logic [1:0]    state_r, state_nxt;
  logic [AW-1:0] pos_r, pos_nxt, cnt_r, cnt_nxt, clr_r, clr_nxt;
  logic          op_r, op_nxt;
  logic [63:0]   key_r, key_nxt, val_r, val_nxt;
  logic          ov_r, ov_nxt;
  logic [2:0]    ost_r, ost_nxt;
  logic [63:0]   oval_r, oval_nxt;

  logic [AW-1:0] rd_addr, wr_addr;
  logic          key_we, val_we, vld_we, vld_wd, pop;
  logic [63:0]   key_rd_r, val_rd_r;
  logic          vld_rd_r;

  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    cnt_nxt   = cnt_r;
    clr_nxt   = clr_r;
    op_nxt    = op_r;
    key_nxt   = key_r;
    val_nxt   = val_r;
    ov_nxt    = 1'b0;
    ost_nxt   = ost_r;
    oval_nxt  = oval_r;
    rd_addr   = pos_r;
    wr_addr   = pos_r;
    key_we    = 1'b0;
    val_we    = 1'b0;
    vld_we    = 1'b0;
    vld_wd    = 1'b0;
    pop       = 1'b0;
    case (state_r)
      S_CLR: begin
        wr_addr = clr_r;
        vld_we  = 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == {AW{1'b1}}) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        // the pass through S_IDLE after every write keeps reads clear of the write port
        if (!q_empty) begin
          pop       = 1'b1;
          op_nxt    = q_item.op;
          key_nxt   = q_item.key;
          val_nxt   = q_item.val;
          pos_nxt   = q_pos;
          cnt_nxt   = '0;
          rd_addr   = q_pos;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        oval_nxt = '0;
        if (!vld_rd_r) begin
          if (op_r == OP_INSERT) begin
            key_we  = 1'b1;
            val_we  = 1'b1;
            vld_we  = 1'b1;
            vld_wd  = 1'b1;
            ost_nxt = STAT_INSERTED;
          end else begin
            ost_nxt = STAT_MISS;
          end
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end else if (key_rd_r == key_r) begin
          if (op_r == OP_INSERT) begin
            val_we  = 1'b1;
            ost_nxt = STAT_UPDATED;
          end else begin
            ost_nxt  = STAT_HIT;
            oval_nxt = val_rd_r;
          end
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end else if (cnt_r == {AW{1'b1}}) begin
          ost_nxt   = (op_r == OP_INSERT) ? STAT_FULL : STAT_MISS;
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          pos_nxt = pos_r + 1'b1;
          cnt_nxt = cnt_r + 1'b1;
          rd_addr = pos_r + 1'b1;
        end
      end
      default: begin
        state_nxt = S_CLR;
        clr_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r  <= pos_nxt;
    cnt_r  <= cnt_nxt;
    op_r   <= op_nxt;
    key_r  <= key_nxt;
    val_r  <= val_nxt;
    ost_r  <= ost_nxt;
    oval_r <= oval_nxt;
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[wr_addr] <= key_r;
    end
    key_rd_r <= key_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (val_we) begin
      val_mem[wr_addr] <= val_r;
    end
    val_rd_r <= val_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (vld_we) begin
      vld_mem[wr_addr] <= vld_wd;
    end
    vld_rd_r <= vld_mem[rd_addr];
  end

  assign bstat.clearing = (state_r == S_CLR);
  assign bstat.pop      = pop;
  assign out_valid      = ov_r;
  assign out_status     = ost_r;
  assign out_read_value = oval_r;

endmodule

>>> rtl/core/linear_probe_hash_table_unit.sv
// Top level of the linear probing hash table: hash front, queue, probe back.
// Depends on lph_pkg, lph_hash_front, lph_queue, lph_probe_back.
//
//   channel   | ports                                  | handshake
//   ----------+----------------------------------------+---------------------------
//   input     | in_opcode, in_lookup_key, in_write_value | start && !busy
//   result    | out_status, out_read_value             | out_valid, one-cycle strobe
//
// A transaction passes through the hash pipeline, then the probe engine, which
// makes one registered memory read per slot that it visits.
// Reset starts a clearing pass over the valid bits, with busy high until it
// ends. Up to four transactions sit in the hash pipeline and queue together;
// busy rises when all four places are taken. Results cannot be held off by the receiver.
module linear_probe_hash_table_unit import lph_pkg::*; #(
  parameter int TABLE_SLOTS = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_opcode,
  input  logic [63:0] in_lookup_key,
  input  logic [63:0] in_write_value,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [63:0] out_read_value
);

  localparam int AW = $clog2(TABLE_SLOTS);

  back_stat_t    bstat;
  logic          push, q_empty;
  item_t         push_item, head_item;
  logic [AW-1:0] push_pos, head_pos;

  lph_hash_front #(.AW(AW)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_opcode      (in_opcode),
    .in_lookup_key  (in_lookup_key),
    .in_write_value (in_write_value),
    .bstat          (bstat),
    .push           (push),
    .push_item      (push_item),
    .push_pos       (push_pos)
  );

  lph_queue #(.AW(AW)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .push_pos  (push_pos),
    .pop       (bstat.pop),
    .empty     (q_empty),
    .head_item (head_item),
    .head_pos  (head_pos)
  );

  lph_probe_back #(.SLOTS(TABLE_SLOTS), .AW(AW)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_item         (head_item),
    .q_pos          (head_pos),
    .bstat          (bstat),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_read_value (out_read_value)
  );

endmodule
